[sv/bdtc_pkg.sv]
// shared types and constants for the button debounce and tap classifier
package bdtc_pkg;

   typedef enum logic [1:0] {
      CMD_TICK   = 2'd0,
      CMD_STOP   = 2'd1,
      CMD_SET_MT = 2'd2,
      CMD_RSVD   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      EV_PRESS   = 2'd0,
      EV_RELEASE = 2'd1,
      EV_LONG    = 2'd2,
      EV_MULTI   = 2'd3
   } event_kind_type;

   typedef enum logic [1:0] {
      CSR_DEBOUNCE = 2'd0,
      CSR_LONG     = 2'd1,
      CSR_REPEAT   = 2'd2,
      CSR_WINDOW   = 2'd3
   } csr_index_type;

   localparam logic [7:0]  DEBOUNCE_RESET = 8'd20;
   localparam logic [15:0] LONG_RESET     = 16'd1000;
   localparam logic [15:0] REPEAT_RESET   = 16'd5;
   localparam logic [15:0] WINDOW_RESET   = 16'd300;

   typedef struct packed {
      cmd_type kind;
      logic    pin_level;
      logic    tab_mode;
   } op_type;

endpackage

[sv/bdtc_front.sv]
// front stage: accepts request transfers, decodes them and drops unused commands
module bdtc_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [1:0]       req_cmd,
   input  logic             req_pin_level,
   input  logic             req_tab_mode,
   output logic             op_valid,
   input  logic             op_ready,
   output bdtc_pkg::op_type op_data
);

   logic             valid_ff, valid_in;
   bdtc_pkg::op_type op_ff, op_in;
   logic             keep;

   assign req_ready = !valid_ff || op_ready;
   assign keep      = (req_cmd != bdtc_pkg::CMD_RSVD);

   always_comb begin
      valid_in = valid_ff && !op_ready;
      op_in    = op_ff;
      if (req_valid && req_ready) begin
         valid_in          = keep;
         op_in.kind        = bdtc_pkg::cmd_type'(req_cmd);
         op_in.pin_level   = req_pin_level;
         op_in.tab_mode    = req_tab_mode;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      op_ff <= op_in;
   end

   assign op_valid = valid_ff;
   assign op_data  = op_ff;

endmodule

[sv/bdtc_queue.sv]
// two-entry queue between the decode front and the execute back
module bdtc_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  bdtc_pkg::op_type in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output bdtc_pkg::op_type out_data
);

   bdtc_pkg::op_type mem_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             push, pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

[sv/bdtc_back.sv]
// execute stage: settings, debouncer, classifier, timers and result register
module bdtc_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [15:0]      csr_wdata,
   input  logic             op_valid,
   output logic             op_ready,
   input  bdtc_pkg::op_type op_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [1:0]       rsp_event_kind,
   output logic [3:0]       rsp_tap_count
);

   logic [7:0]  debounce_ticks_ff;
   logic [15:0] long_press_ticks_ff, repeat_ticks_ff, window_ticks_ff;

   logic        phase_ff, phase_in;
   logic [7:0]  db_count_ff, db_count_in;
   logic        captured_ff, captured_in;
   logic        stable_ff, stable_in;
   logic        level_now_ff, level_now_in;
   logic        level_prev_ff, level_prev_in;
   logic        level_prev2_ff, level_prev2_in;
   logic        long_armed_ff, long_armed_in;
   logic        multi_off_ff, multi_off_in;
   logic [3:0]  tap_ff, tap_in;
   logic [15:0] long_timer_ff, long_timer_in;
   logic [15:0] multi_timer_ff, multi_timer_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   bdtc_pkg::event_kind_type rsp_kind_ff, rsp_kind_in;
   logic [3:0]               rsp_count_ff, rsp_count_in;

   logic        exec;
   logic        emit;
   logic [15:0] long_dec, multi_dec;
   logic [3:0]  tap_next;

   assign op_ready = !rsp_valid_ff || rsp_ready;
   assign exec     = op_valid && op_ready;
   assign long_dec  = (long_timer_ff != 16'd0) ? long_timer_ff - 16'd1 : 16'd0;
   assign multi_dec = (multi_timer_ff != 16'd0) ? multi_timer_ff - 16'd1 : 16'd0;
   assign tap_next  = tap_ff + 4'd1;

   always_comb begin
      phase_in       = phase_ff;
      db_count_in    = db_count_ff;
      captured_in    = captured_ff;
      stable_in      = stable_ff;
      level_now_in   = level_now_ff;
      level_prev_in  = level_prev_ff;
      level_prev2_in = level_prev2_ff;
      long_armed_in  = long_armed_ff;
      multi_off_in   = multi_off_ff;
      tap_in         = tap_ff;
      long_timer_in  = long_timer_ff;
      multi_timer_in = multi_timer_ff;
      emit           = 1'b0;
      rsp_kind_in    = rsp_kind_ff;
      rsp_count_in   = rsp_count_ff;
      if (exec) begin
         case (op_data.kind)
            bdtc_pkg::CMD_STOP: begin
               long_armed_in = 1'b0;
            end
            bdtc_pkg::CMD_SET_MT: begin
               multi_off_in = op_data.tab_mode;
            end
            bdtc_pkg::CMD_TICK: begin
               long_timer_in  = long_dec;
               multi_timer_in = multi_dec;
               // debouncer
               if (!phase_ff) begin
                  db_count_in = debounce_ticks_ff;
                  captured_in = op_data.pin_level;
                  phase_in    = 1'b1;
               end else if (captured_ff != op_data.pin_level) begin
                  phase_in = 1'b0;
               end else if (db_count_ff != 8'd0) begin
                  db_count_in = db_count_ff - 8'd1;
               end else begin
                  stable_in = captured_ff;
                  phase_in  = 1'b0;
               end
               // classifier
               if (level_now_ff == stable_in) begin
                  if (long_armed_ff && long_dec == 16'd0) begin
                     long_timer_in = repeat_ticks_ff;
                     emit          = 1'b1;
                     rsp_kind_in   = bdtc_pkg::EV_LONG;
                     rsp_count_in  = 4'd0;
                  end
               end else begin
                  level_prev2_in = level_prev_ff;
                  level_prev_in  = level_now_ff;
                  level_now_in   = stable_in;
                  if (!stable_in) begin
                     long_armed_in = 1'b0;
                     emit          = 1'b1;
                     rsp_kind_in   = bdtc_pkg::EV_RELEASE;
                     rsp_count_in  = 4'd0;
                  end else begin
                     long_armed_in  = 1'b1;
                     long_timer_in  = long_press_ticks_ff;
                     multi_timer_in = window_ticks_ff;
                     if (level_prev_ff && !multi_off_ff) begin
                        if (multi_dec == 16'd0) begin
                           tap_in       = 4'd0;
                           emit         = 1'b1;
                           rsp_kind_in  = bdtc_pkg::EV_MULTI;
                           rsp_count_in = tap_next;
                        end else begin
                           tap_in = tap_next;
                        end
                     end else begin
                        tap_in       = 4'd0;
                        multi_off_in = 1'b0;
                        emit         = 1'b1;
                        rsp_kind_in  = bdtc_pkg::EV_PRESS;
                        rsp_count_in = 4'd0;
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end
      rsp_valid_in = emit || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ticks_ff   <= bdtc_pkg::DEBOUNCE_RESET;
         long_press_ticks_ff <= bdtc_pkg::LONG_RESET;
         repeat_ticks_ff     <= bdtc_pkg::REPEAT_RESET;
         window_ticks_ff     <= bdtc_pkg::WINDOW_RESET;
      end else if (csr_we) begin
         case (csr_index)
            bdtc_pkg::CSR_DEBOUNCE: debounce_ticks_ff   <= csr_wdata[7:0];
            bdtc_pkg::CSR_LONG:     long_press_ticks_ff <= csr_wdata;
            bdtc_pkg::CSR_REPEAT:   repeat_ticks_ff     <= csr_wdata;
            bdtc_pkg::CSR_WINDOW:   window_ticks_ff     <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= 1'b0;
         db_count_ff    <= 8'd0;
         captured_ff    <= 1'b1;
         stable_ff      <= 1'b1;
         level_now_ff   <= 1'b0;
         level_prev_ff  <= 1'b0;
         level_prev2_ff <= 1'b0;
         long_armed_ff  <= 1'b0;
         multi_off_ff   <= 1'b0;
         tap_ff         <= 4'd0;
         long_timer_ff  <= 16'd0;
         multi_timer_ff <= 16'd0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         db_count_ff    <= db_count_in;
         captured_ff    <= captured_in;
         stable_ff      <= stable_in;
         level_now_ff   <= level_now_in;
         level_prev_ff  <= level_prev_in;
         level_prev2_ff <= level_prev2_in;
         long_armed_ff  <= long_armed_in;
         multi_off_ff   <= multi_off_in;
         tap_ff         <= tap_in;
         long_timer_ff  <= long_timer_in;
         multi_timer_ff <= multi_timer_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      rsp_kind_ff  <= rsp_kind_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_event_kind = rsp_kind_ff;
   assign rsp_tap_count  = rsp_count_ff;

endmodule

[sv/button_debounce_tap_classifier.sv]
// top level of the button debounce and tap classifier
// Takes one request transfer per clock while the queue has room and executes
// one command per clock unless stalled; a tick yields at most one event. A
// request passes the decode register, a two-entry queue and the execute
// stage, whose result register drives rsp_valid. The execute stage, which
// updates debouncer, classifier and both timers together, sets the rate; it
// stalls only while an event waits in the result register and rsp_ready is
// low; the queue lets the front keep taking transfers until it fills. Unused
// command code 3 is dropped at decode. Settings are written through csr_we,
// csr_index and csr_wdata by the user only while the block is idle; unchecked.
module button_debounce_tap_classifier (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_cmd,
   input  logic        req_pin_level,
   input  logic        req_tab_mode,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_event_kind,
   output logic [3:0]  rsp_tap_count
);

   logic             front_valid, front_ready;
   bdtc_pkg::op_type front_op;
   logic             queue_valid, queue_ready;
   bdtc_pkg::op_type queue_op;

   bdtc_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_cmd       (req_cmd),
      .req_pin_level (req_pin_level),
      .req_tab_mode  (req_tab_mode),
      .op_valid      (front_valid),
      .op_ready      (front_ready),
      .op_data       (front_op)
   );

   bdtc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_data   (front_op),
      .out_valid (queue_valid),
      .out_ready (queue_ready),
      .out_data  (queue_op)
   );

   bdtc_back u_back (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .op_valid       (queue_valid),
      .op_ready       (queue_ready),
      .op_data        (queue_op),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_event_kind (rsp_event_kind),
      .rsp_tap_count  (rsp_tap_count)
   );

   // only a multi tap carries a count
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_kind != bdtc_pkg::EV_MULTI) |-> rsp_tap_count == 4'd0)
      else $error("tap count on a non multi tap event");

   // decoded op waiting on a full queue is held
   assert property (@(posedge clock) disable iff (reset)
      front_valid && !front_ready |=> front_valid && $stable(front_op))
      else $error("decoded op lost while queue full");

   // the execute stage never consumes while a stalled event is pending
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !queue_ready)
      else $error("execute stage ran over a pending event");

   // no event right after reset
   assert property (@(posedge clock) $fell(reset) |-> !rsp_valid)
      else $error("event out of reset");

endmodule
